// ===== hw/rtl/rbmo_pkg.sv =====
// Shared constants and types for the RGB565 box and marker overlay.
package rbmo_pkg;

  localparam int COORD_BITS = 12;
  localparam int SCOORD_BITS = COORD_BITS + 3;
  localparam int PIX_BITS = 16;
  localparam int CFG_INDEX_BITS = 3;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic signed [SCOORD_BITS-1:0] scoord_t;
  typedef logic [PIX_BITS-1:0] pix_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_BOX_ENABLE   = 3'd2,
    CFG_BOX_LEFT     = 3'd3,
    CFG_BOX_TOP      = 3'd4,
    CFG_BOX_SPAN_X   = 3'd5,
    CFG_BOX_SPAN_Y   = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    coord_t frame_width;
    coord_t frame_height;
    logic   box_enable;
    coord_t box_left;
    coord_t box_top;
    coord_t box_span_x;
    coord_t box_span_y;
  } cfg_t;

  localparam coord_t RESET_FRAME_WIDTH  = COORD_BITS'(320);
  localparam coord_t RESET_FRAME_HEIGHT = COORD_BITS'(240);

  localparam pix_t CLR_RED    = 16'hF800;
  localparam pix_t CLR_GREEN  = 16'h07E0;
  localparam pix_t CLR_BLUE   = 16'h001F;
  localparam pix_t CLR_YELLOW = 16'hFFE0;
  localparam pix_t CLR_CYAN   = 16'h07FF;
  localparam pix_t CLR_WHITE  = 16'hFFFF;

  localparam scoord_t CROSS_HALF   = SCOORD_BITS'(50);
  localparam scoord_t MARK_MARGIN  = SCOORD_BITS'(30);
  localparam scoord_t MARK_LEN     = SCOORD_BITS'(20);
  localparam scoord_t BORDER_EXTRA = SCOORD_BITS'(3 - 1);

endpackage

// ===== hw/rtl/rbmo_overlay.sv =====
// Combinational paint logic: cross, corner marks, box border and center point.
module rbmo_overlay (
  input  rbmo_pkg::cfg_t   cfg,
  input  rbmo_pkg::coord_t pix_col,
  input  rbmo_pkg::coord_t pix_row,
  input  rbmo_pkg::pix_t   pix_in,
  output rbmo_pkg::pix_t   pix_out
);

  rbmo_pkg::scoord_t x, y, w, h, cx, cy, m, l;
  rbmo_pkg::scoord_t bl, bt, sx, sy, x1, y1, x2, y2, x2c, y2c, t;
  rbmo_pkg::scoord_t ctr_x, ctr_y;
  logic in_frame, cross_hit, blue_hit, yellow_hit, cyan_hit, red_hit;
  logic border_ok, rows_hit, cols_hit, center_hit;

  always_comb begin
    x = rbmo_pkg::SCOORD_BITS'(pix_col);
    y = rbmo_pkg::SCOORD_BITS'(pix_row);
    w = rbmo_pkg::SCOORD_BITS'(cfg.frame_width);
    h = rbmo_pkg::SCOORD_BITS'(cfg.frame_height);
    m = rbmo_pkg::MARK_MARGIN;
    l = rbmo_pkg::MARK_LEN;
    t = rbmo_pkg::BORDER_EXTRA;
    cx = w >>> 1;
    cy = h >>> 1;

    in_frame = (pix_col < cfg.frame_width) && (pix_row < cfg.frame_height);

    cross_hit = ((y == cy) && (x >= cx - rbmo_pkg::CROSS_HALF) &&
                 (x <= cx + rbmo_pkg::CROSS_HALF)) ||
                ((x == cx) && (y >= cy - rbmo_pkg::CROSS_HALF) &&
                 (y <= cy + rbmo_pkg::CROSS_HALF));
    blue_hit = ((y == m) && (x >= m) && (x <= m + l)) ||
               ((x == m) && (y >= m) && (y <= m + l));
    yellow_hit = ((y == m) && (x >= w - m - l) && (x <= w - m)) ||
                 ((x == w - m) && (y >= m) && (y <= m + l));
    cyan_hit = ((y == h - m) && (x >= m) && (x <= m + l)) ||
               ((x == m) && (y >= h - m - l) && (y <= h - m));
    red_hit = ((y == h - m) && (x >= w - m - l) && (x <= w - m)) ||
              ((x == w - m) && (y >= h - m - l) && (y <= h - m));

    bl = rbmo_pkg::SCOORD_BITS'(signed'(cfg.box_left));
    bt = rbmo_pkg::SCOORD_BITS'(signed'(cfg.box_top));
    sx = rbmo_pkg::SCOORD_BITS'(cfg.box_span_x);
    sy = rbmo_pkg::SCOORD_BITS'(cfg.box_span_y);
    x2 = bl + sx;
    y2 = bt + sy;
    x1 = bl[rbmo_pkg::SCOORD_BITS-1] ? '0 : bl;
    y1 = bt[rbmo_pkg::SCOORD_BITS-1] ? '0 : bt;
    x2c = (x2 >= w) ? w - rbmo_pkg::scoord_t'(1) : x2;
    y2c = (y2 >= h) ? h - rbmo_pkg::scoord_t'(1) : y2;
    border_ok = (sx != 0) && (sy != 0) && (x1 < x2c) && (y1 < y2c);
    rows_hit = (((y >= y1) && (y <= y1 + t)) || ((y >= y2c - t) && (y <= y2c))) &&
               (x >= x1) && (x <= x2c);
    cols_hit = (((x >= x1) && (x <= x1 + t)) || ((x >= x2c - t) && (x <= x2c))) &&
               (y >= y1) && (y <= y2c);

    ctr_x = bl + (sx >>> 1);
    ctr_y = bt + (sy >>> 1);
    center_hit = (x == ctr_x) && (y == ctr_y);

    pix_out = pix_in;
    if (in_frame) begin
      if (cross_hit) pix_out = rbmo_pkg::CLR_GREEN;
      if (blue_hit) pix_out = rbmo_pkg::CLR_BLUE;
      if (yellow_hit) pix_out = rbmo_pkg::CLR_YELLOW;
      if (cyan_hit) pix_out = rbmo_pkg::CLR_CYAN;
      if (red_hit) pix_out = rbmo_pkg::CLR_RED;
      if (cfg.box_enable && border_ok && (rows_hit || cols_hit)) pix_out = rbmo_pkg::CLR_RED;
      if (cfg.box_enable && center_hit) pix_out = rbmo_pkg::CLR_WHITE;
    end
  end

endmodule

// ===== hw/rtl/rgb565_box_and_marker_overlay.sv =====
// Top level of the RGB565 box and marker overlay: config registers and pixel pipeline.
// An accepted pixel is held in the input register, then its result is registered in the result register with done high.
// Throughput: one pixel per clock; busy stays low, one input register and one result register.
// Each pixel is a single pass of compare logic between the two registers.
// Reset (rst, synchronous, active high) clears the pipeline valid bits and loads the
// register defaults: frame 320 x 240, box disabled, box at 0 with zero spans.
module rgb565_box_and_marker_overlay (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  rbmo_pkg::coord_t                      pix_col,
  input  rbmo_pkg::coord_t                      pix_row,
  input  rbmo_pkg::pix_t                        pix_in,
  output logic                                  done,
  output rbmo_pkg::pix_t                        pix_out,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [rbmo_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  rbmo_pkg::coord_t                      cfg_data
);

  rbmo_pkg::cfg_t   cfg;
  logic             valid_q;
  rbmo_pkg::coord_t col_q, row_q;
  rbmo_pkg::pix_t   pix_q;
  rbmo_pkg::pix_t   pix_next;
  logic             accept;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width <= rbmo_pkg::RESET_FRAME_WIDTH;
      cfg.frame_height <= rbmo_pkg::RESET_FRAME_HEIGHT;
      cfg.box_enable <= 1'b0;
      cfg.box_left <= '0;
      cfg.box_top <= '0;
      cfg.box_span_x <= '0;
      cfg.box_span_y <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rbmo_pkg::CFG_FRAME_WIDTH:  cfg.frame_width <= cfg_data;
        rbmo_pkg::CFG_FRAME_HEIGHT: cfg.frame_height <= cfg_data;
        rbmo_pkg::CFG_BOX_ENABLE:   cfg.box_enable <= cfg_data[0];
        rbmo_pkg::CFG_BOX_LEFT:     cfg.box_left <= cfg_data;
        rbmo_pkg::CFG_BOX_TOP:      cfg.box_top <= cfg_data;
        rbmo_pkg::CFG_BOX_SPAN_X:   cfg.box_span_x <= cfg_data;
        rbmo_pkg::CFG_BOX_SPAN_Y:   cfg.box_span_y <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
      done <= 1'b0;
    end else begin
      valid_q <= accept;
      done <= valid_q;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      col_q <= pix_col;
      row_q <= pix_row;
      pix_q <= pix_in;
    end
    if (valid_q) begin
      pix_out <= pix_next;
    end
  end

  rbmo_overlay u_overlay (
    .cfg     (cfg),
    .pix_col (col_q),
    .pix_row (row_q),
    .pix_in  (pix_q),
    .pix_out (pix_next)
  );

  a_accept_reaches_stage: assert property (@(posedge clk) disable iff (rst)
    accept |=> valid_q)
    else $error("accepted transaction did not enter the input register");

  a_stage_gives_done: assert property (@(posedge clk) disable iff (rst)
    valid_q |=> done)
    else $error("registered transaction produced no result strobe");

  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(valid_q))
    else $error("result strobe without a transaction in flight");

  a_outside_untouched: assert property (@(posedge clk) disable iff (rst)
    (valid_q && ((col_q >= cfg.frame_width) || (row_q >= cfg.frame_height)))
      |=> (pix_out == $past(pix_q)))
    else $error("pixel outside the frame was repainted");

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the RGB565 box and marker overlay.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rbmo_pkg::*;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_INDEX_NONE = 3'd7;
  localparam int HALF = int'(CROSS_HALF);
  localparam int MARGIN = int'(MARK_MARGIN);
  localparam int LEN = int'(MARK_LEN);
  localparam int EXTRA = int'(BORDER_EXTRA);

  logic clk;
  logic rst;
  logic start;
  logic busy;
  coord_t pix_col;
  coord_t pix_row;
  pix_t pix_in;
  logic done;
  pix_t pix_out;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  coord_t cfg_data;

  cfg_t cfg_shadow;
  pix_t expected_pix[$];
  int mismatch_count = 0;
  int sender_idle_pct = 0;

  rgb565_box_and_marker_overlay u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .pix_col(pix_col),
    .pix_row(pix_row),
    .pix_in(pix_in),
    .done(done),
    .pix_out(pix_out),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic bit in_range(int v, int lo, int hi);
    return v >= lo && v <= hi;
  endfunction

  function automatic bit on_row_seg(int x, int y, int r, int a, int b);
    return y == r && in_range(x, a, b);
  endfunction

  function automatic bit on_col_seg(int x, int y, int c, int a, int b);
    return x == c && in_range(y, a, b);
  endfunction

  function automatic pix_t overlay_pixel(coord_t col, coord_t row, pix_t base);
    int x, y, w, h, cx, cy, bl, bt, sx, sy, x1, y1, x2, y2;
    pix_t p;
    x = int'(col);
    y = int'(row);
    w = int'(cfg_shadow.frame_width);
    h = int'(cfg_shadow.frame_height);
    p = base;
    if (x >= w || y >= h) return p;
    cx = w / 2;
    cy = h / 2;
    if (on_row_seg(x, y, cy, cx - HALF, cx + HALF) ||
        on_col_seg(x, y, cx, cy - HALF, cy + HALF)) p = CLR_GREEN;
    if (on_row_seg(x, y, MARGIN, MARGIN, MARGIN + LEN) ||
        on_col_seg(x, y, MARGIN, MARGIN, MARGIN + LEN)) p = CLR_BLUE;
    if (on_row_seg(x, y, MARGIN, w - MARGIN - LEN, w - MARGIN) ||
        on_col_seg(x, y, w - MARGIN, MARGIN, MARGIN + LEN)) p = CLR_YELLOW;
    if (on_row_seg(x, y, h - MARGIN, MARGIN, MARGIN + LEN) ||
        on_col_seg(x, y, MARGIN, h - MARGIN - LEN, h - MARGIN)) p = CLR_CYAN;
    if (on_row_seg(x, y, h - MARGIN, w - MARGIN - LEN, w - MARGIN) ||
        on_col_seg(x, y, w - MARGIN, h - MARGIN - LEN, h - MARGIN)) p = CLR_RED;
    if (!cfg_shadow.box_enable) return p;
    bl = int'($signed(cfg_shadow.box_left));
    bt = int'($signed(cfg_shadow.box_top));
    sx = int'(cfg_shadow.box_span_x);
    sy = int'(cfg_shadow.box_span_y);
    if (sx > 0 && sy > 0) begin
      x1 = (bl < 0) ? 0 : bl;
      y1 = (bt < 0) ? 0 : bt;
      x2 = (bl + sx >= w) ? w - 1 : bl + sx;
      y2 = (bt + sy >= h) ? h - 1 : bt + sy;
      if (x1 < x2 && y1 < y2 &&
          (((in_range(y, y1, y1 + EXTRA) || in_range(y, y2 - EXTRA, y2)) &&
            in_range(x, x1, x2)) ||
           ((in_range(x, x1, x1 + EXTRA) || in_range(x, x2 - EXTRA, x2)) &&
            in_range(y, y1, y2)))) p = CLR_RED;
    end
    if (x == bl + sx / 2 && y == bt + sy / 2) p = CLR_WHITE;
    return p;
  endfunction

  always @(posedge clk) begin : check_results
    pix_t want;
    if (!rst && done) begin
      if (expected_pix.size() == 0) begin
        report_mismatch($sformatf("result 0x%04h with no pixel outstanding", pix_out));
      end else begin
        want = expected_pix.pop_front();
        if (pix_out !== want)
          report_mismatch($sformatf("pix_out 0x%04h, expected 0x%04h", pix_out, want));
      end
    end
  end

  task automatic send_pixel(input coord_t col, input coord_t row, input pix_t color);
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    pix_col <= col;
    pix_row <= row;
    pix_in <= color;
    do @(posedge clk); while (busy);
    expected_pix.push_back(overlay_pixel(col, row, color));
  endtask

  task automatic drain_pipeline();
    @(negedge clk);
    start <= 1'b0;
    for (int i = 0; i < 200 && expected_pix.size() != 0; i++) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input coord_t data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_FRAME_WIDTH:  cfg_shadow.frame_width = data;
      CFG_FRAME_HEIGHT: cfg_shadow.frame_height = data;
      CFG_BOX_ENABLE:   cfg_shadow.box_enable = data[0];
      CFG_BOX_LEFT:     cfg_shadow.box_left = data;
      CFG_BOX_TOP:      cfg_shadow.box_top = data;
      CFG_BOX_SPAN_X:   cfg_shadow.box_span_x = data;
      CFG_BOX_SPAN_Y:   cfg_shadow.box_span_y = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic coord_t extreme_size();
    case ($urandom_range(0, 2))
      0: return coord_t'(0);
      1: return coord_t'(1);
      default: return coord_t'(4095);
    endcase
  endfunction

  // pick a coordinate close to something the overlay draws
  function automatic coord_t pick_coord(bit along_rows);
    int span, lo, ext, anchor;
    span = along_rows ? int'(cfg_shadow.frame_height) : int'(cfg_shadow.frame_width);
    lo = along_rows ? int'($signed(cfg_shadow.box_top)) : int'($signed(cfg_shadow.box_left));
    ext = along_rows ? int'(cfg_shadow.box_span_y) : int'(cfg_shadow.box_span_x);
    case ($urandom_range(0, 11))
      0: anchor = 0;
      1: anchor = span / 2;
      2: anchor = span / 2 - HALF;
      3: anchor = span / 2 + HALF;
      4: anchor = MARGIN;
      5: anchor = MARGIN + LEN;
      6: anchor = span - MARGIN;
      7: anchor = span - MARGIN - LEN;
      8: anchor = lo;
      9: anchor = lo + ext;
      10: anchor = lo + ext / 2;
      default: anchor = span - 1;
    endcase
    return coord_t'(anchor + int'($urandom_range(0, 6)) - 3);
  endfunction

  task automatic randomize_config();
    coord_t w, h, data;
    w = ($urandom_range(0, 9) == 0) ? extreme_size() : coord_t'($urandom_range(1, 400));
    h = ($urandom_range(0, 9) == 0) ? extreme_size() : coord_t'($urandom_range(1, 400));
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    data = coord_t'($urandom);
    data[0] = ($urandom_range(0, 4) != 0);
    write_reg(CFG_BOX_ENABLE, data);
    for (int axis = 0; axis < 2; axis++) begin
      if ($urandom_range(0, 4) == 0) data = coord_t'($urandom);
      else data = coord_t'(int'($urandom_range(0, (axis ? h : w) + 40)) - 40);
      write_reg(axis ? CFG_BOX_TOP : CFG_BOX_LEFT, data);
      case ($urandom_range(0, 7))
        0: data = '0;
        1, 2: data = coord_t'($urandom_range(1, 8));
        3: data = coord_t'($urandom);
        default: data = coord_t'($urandom_range(1, (axis ? h : w) + 1));
      endcase
      write_reg(axis ? CFG_BOX_SPAN_Y : CFG_BOX_SPAN_X, data);
    end
    if ($urandom_range(0, 3) == 0) write_reg(CFG_INDEX_NONE, coord_t'($urandom));
  endtask

  task automatic test_reset_defaults();
    send_pixel(12'd160, 12'd120, 16'h0000);
    send_pixel(12'd110, 12'd120, 16'hFFFF);
    send_pixel(12'd211, 12'd120, 16'h1234);
    send_pixel(12'd160, 12'd170, 16'h0000);
    send_pixel(12'd30, 12'd30, 16'hFFFF);
    send_pixel(12'd50, 12'd30, 16'h0000);
    send_pixel(12'd290, 12'd50, 16'h0000);
    send_pixel(12'd30, 12'd210, 16'h0000);
    send_pixel(12'd290, 12'd210, 16'h0000);
    send_pixel(12'd320, 12'd0, 16'hA5A5);
    send_pixel(12'd4095, 12'd4095, 16'hFFFF);
  endtask

  task automatic test_box_overlay();
    drain_pipeline();
    write_reg(CFG_BOX_ENABLE, 12'h001);
    write_reg(CFG_BOX_LEFT, coord_t'(-5));
    write_reg(CFG_BOX_TOP, 12'd10);
    write_reg(CFG_BOX_SPAN_X, 12'd40);
    write_reg(CFG_BOX_SPAN_Y, 12'd30);
    send_pixel(12'd0, 12'd10, 16'h0000);
    send_pixel(12'd35, 12'd40, 16'h0000);
    send_pixel(12'd3, 12'd20, 16'h5555);
    send_pixel(12'd15, 12'd25, 16'h0000);
    send_pixel(12'd33, 12'd30, 16'h0000);
    drain_pipeline();
    write_reg(CFG_BOX_SPAN_X, 12'd0);
    write_reg(CFG_BOX_LEFT, 12'd100);
    write_reg(CFG_INDEX_NONE, 12'hFFF);
    send_pixel(12'd100, 12'd25, 16'h0000);
    send_pixel(12'd100, 12'd10, 16'h0000);
    drain_pipeline();
    write_reg(CFG_BOX_ENABLE, 12'hFFE);
    send_pixel(12'd100, 12'd25, 16'h0000);
  endtask

  task automatic test_frame_extremes();
    drain_pipeline();
    write_reg(CFG_FRAME_WIDTH, 12'd1);
    write_reg(CFG_FRAME_HEIGHT, 12'd1);
    send_pixel(12'd0, 12'd0, 16'h0000);
    send_pixel(12'd1, 12'd0, 16'h0000);
    drain_pipeline();
    write_reg(CFG_FRAME_WIDTH, 12'd0);
    send_pixel(12'd0, 12'd0, 16'h0000);
    drain_pipeline();
    write_reg(CFG_FRAME_WIDTH, 12'd4095);
    write_reg(CFG_FRAME_HEIGHT, 12'd4095);
    write_reg(CFG_BOX_ENABLE, 12'hFFF);
    write_reg(CFG_BOX_LEFT, 12'd2047);
    write_reg(CFG_BOX_TOP, 12'd2047);
    write_reg(CFG_BOX_SPAN_X, 12'd4095);
    write_reg(CFG_BOX_SPAN_Y, 12'd4095);
    send_pixel(12'd4094, 12'd4094, 16'h0000);
    send_pixel(12'd4093, 12'd4094, 16'h0000);
    send_pixel(12'd4065, 12'd4065, 16'h0000);
    send_pixel(12'd4095, 12'd4095, 16'h0000);
  endtask

  task automatic test_random_overlay(input int idle_pct);
    coord_t col, row;
    sender_idle_pct = idle_pct;
    repeat (4) begin
      drain_pipeline();
      randomize_config();
      repeat (60) begin
        col = ($urandom_range(0, 3) == 0) ? coord_t'($urandom) : pick_coord(1'b0);
        row = ($urandom_range(0, 3) == 0) ? coord_t'($urandom) : pick_coord(1'b1);
        send_pixel(col, row, pix_t'($urandom));
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    pix_col = '0;
    pix_row = '0;
    pix_in = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_FRAME_WIDTH;
    cfg_data = '0;
    cfg_shadow = '0;
    cfg_shadow.frame_width = RESET_FRAME_WIDTH;
    cfg_shadow.frame_height = RESET_FRAME_HEIGHT;
    sender_idle_pct = 32;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_box_overlay();
    test_frame_extremes();
    test_random_overlay(32);
    test_random_overlay(67);
    test_random_overlay(0);
    drain_pipeline();
    if (expected_pix.size() != 0)
      report_mismatch($sformatf("%0d pixels never came back", expected_pix.size()));
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== rgb565_box_and_marker_overlay.f =====
hw/rtl/rbmo_pkg.sv
hw/rtl/rbmo_overlay.sv
hw/rtl/rgb565_box_and_marker_overlay.sv
tb/sv/tb.sv
